### rtl/core/rhr_pkg.sv
package rhr_pkg;

  // hue circle constants in degrees
  localparam int HUE_FULL  = 360;
  localparam int HUE_THIRD = 120;
  localparam int HUE_SIXTH = 60;

  // floor(x / 60) as (x * RECIP_SIXTH) >> RECIP_SHIFT, exact for x below 2^14
  localparam int          RECIP_SHIFT = 20;
  localparam logic [14:0] RECIP_SIXTH = 15'd17477;

  // hue divider: 60 * sector offset over chroma, quotient below 360
  localparam int NUM_W      = 17;
  localparam int QUO_W      = 9;
  localparam int DIV_STAGES = 3;
  localparam int DIV_BITS   = 3;

  typedef struct packed {
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
    logic signed [15:0] shift_degrees;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pixel_out_t;

  // data that rides along the pipeline next to the hue math
  typedef struct packed {
    pixel_in_t  px;
    logic [7:0] lo;
    logic [7:0] chroma;
    logic       bypass;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [7:0]       den;
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    side_t            side;
  } div_out_t;

endpackage

### rtl/core/rhr_div.sv
module rhr_div
  import rhr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output div_out_t out_data
);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [7:0]       den;
    side_t            side;
  } div_stage_t;

  div_stage_t            st      [DIV_STAGES];
  div_stage_t            st_next [DIV_STAGES];
  div_stage_t            st_src  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] rdy;

  // word entering each stage: the input word first, then the previous stage
  always_comb begin
    st_src[0].rem  = in_data.num;
    st_src[0].quo  = '0;
    st_src[0].den  = in_data.den;
    st_src[0].side = in_data.side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_src[s] = st[s-1];
    end
  end

  // restoring division, DIV_BITS quotient bits per stage, msb first
  always_comb begin
    div_stage_t       cur;
    logic [NUM_W-1:0] trial;
    int               k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      cur = st_src[s];
      for (int b = 0; b < DIV_BITS; b++) begin
        k     = QUO_W - 1 - s * DIV_BITS - b;
        trial = NUM_W'(cur.den) << k;
        if (cur.rem >= trial) begin
          cur.rem    = cur.rem - trial;
          cur.quo[k] = 1'b1;
        end
      end
      st_next[s] = cur;
    end
  end

  // a stage takes a new word when it is empty or its word moves on
  always_comb begin
    rdy[DIV_STAGES-1] = !vld[DIV_STAGES-1] || out_ready;
    for (int s = DIV_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld[DIV_STAGES-1];
  assign out_data.quo  = st[DIV_STAGES-1].quo;
  assign out_data.side = st[DIV_STAGES-1].side;

endmodule

### rtl/core/rgb_hue_rotation_unit.sv
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | in_data  (pixel_in_t: rgba + shift)
// out     | output    | out_valid / out_ready | out_data (pixel_out_t: rgba)
//
// one pixel per clock sustained while out_ready stays high
// stages: min/max, three divider stages, shift, two mod-360 stages, sector, scale, output
// the per-stage reciprocal multiply and the restoring divider steps set the stage depth
// rst (synchronous) clears every stage valid bit; payload registers are not reset
// each stage has its own valid bit, so an empty stage takes a word even while out stalls
module rgb_hue_rotation_unit
  import rhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pixel_out_t out_data
);

  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  typedef struct packed {
    logic [15:0] mag;
    side_t       side;
  } st5_t;

  typedef struct packed {
    logic [15:0] rem;
    side_t       side;
  } st6_t;

  typedef struct packed {
    logic [8:0] hue;
    side_t      side;
  } st7_t;

  typedef struct packed {
    logic [13:0] prod;
    sector_t     sect;
    side_t       side;
  } st8_t;

  typedef struct packed {
    logic [7:0] cc;
    sector_t    sect;
    side_t      side;
  } st9_t;

  // conditional subtracts of 360 << k for k from hi_k down to lo_k
  function automatic logic [15:0] mod_steps(input logic [15:0] v, input int hi_k,
                                            input int lo_k);
    logic [15:0] r;
    logic [15:0] trial;
    r = v;
    for (int k = 6; k >= 0; k--) begin
      trial = 16'(HUE_FULL << k);
      if (k <= hi_k && k >= lo_k && r >= trial) begin
        r = r - trial;
      end
    end
    return r;
  endfunction

  div_in_t    s1, s1_next;
  div_out_t   div_out;
  st5_t       s5, s5_next;
  st6_t       s6, s6_next;
  st7_t       s7, s7_next;
  st8_t       s8, s8_next;
  st9_t       s9, s9_next;
  pixel_out_t s10_next;

  logic v1, v5, v6, v7, v8, v9, v10;
  logic r1, r5, r6, r7, r8, r9, r10;
  logic div_in_ready, div_out_valid;

  // stage 1: max, min, chroma and 60 times the sector offset
  always_comb begin
    logic [7:0]         r, g, b, hi, lo, c;
    logic [10:0]        c2, c4, c6;
    logic signed [11:0] hsum;
    logic [10:0]        hnum;
    r    = in_data.red_in;
    g    = in_data.green_in;
    b    = in_data.blue_in;
    hi   = (r > g) ? r : g;
    hi   = (b > hi) ? b : hi;
    lo   = (r < g) ? r : g;
    lo   = (b < lo) ? b : lo;
    c    = hi - lo;
    c2   = {3'b0, c} << 1;
    c4   = {3'b0, c} << 2;
    c6   = c2 + c4;
    if (hi == r) begin
      hsum = $signed({4'b0, g}) - $signed({4'b0, b});
      if (hsum < 0) begin
        hsum = hsum + $signed({1'b0, c6});
      end
    end else if (hi == g) begin
      hsum = $signed({4'b0, b}) - $signed({4'b0, r}) + $signed({1'b0, c2});
    end else begin
      hsum = $signed({4'b0, r}) - $signed({4'b0, g}) + $signed({1'b0, c4});
    end
    hnum                = hsum[10:0];
    s1_next.num         = ({6'b0, hnum} << 6) - ({6'b0, hnum} << 2);
    s1_next.den         = c;
    s1_next.side.px     = in_data;
    s1_next.side.lo     = lo;
    s1_next.side.chroma = c;
    s1_next.side.bypass = (in_data.shift_degrees == 16'sd0) || (hi == lo);
  end

  // stages 2 to 4: hue = 60 * offset / chroma
  rhr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (div_in_ready),
    .in_data   (s1),
    .out_valid (div_out_valid),
    .out_ready (r5),
    .out_data  (div_out)
  );

  // stage 5: add the shift, keep the magnitude
  always_comb begin
    logic signed [16:0] sum;
    logic signed [16:0] mag;
    sum  = $signed({8'b0, div_out.quo}) +
           $signed({div_out.side.px.shift_degrees[15], div_out.side.px.shift_degrees});
    mag  = (sum < 0) ? -sum : sum;
    s5_next.mag  = mag[15:0];
    s5_next.side = div_out.side;
  end

  // stages 6 and 7: magnitude mod 360
  always_comb begin
    logic [15:0] rem7;
    s6_next.rem  = mod_steps(s5.mag, 6, 3);
    s6_next.side = s5.side;
    rem7         = mod_steps(s6.rem, 2, 0);
    s7_next.hue  = rem7[8:0];
    s7_next.side = s6.side;
  end

  // stage 8: sector and chroma times triangle height
  always_comb begin
    logic [8:0]        hm9;
    logic [6:0]        hm;
    logic signed [7:0] d;
    logic [7:0]        ad;
    logic [5:0]        t;
    if (s7.hue >= 9'(2 * HUE_THIRD)) begin
      hm9 = s7.hue - 9'(2 * HUE_THIRD);
    end else if (s7.hue >= 9'(HUE_THIRD)) begin
      hm9 = s7.hue - 9'(HUE_THIRD);
    end else begin
      hm9 = s7.hue;
    end
    hm = hm9[6:0];
    d  = $signed({1'b0, hm}) - 8'sd60;
    ad = (d < 0) ? 8'(-d) : 8'(d);
    t  = 6'(HUE_SIXTH) - ad[5:0];
    if (s7.hue < 9'(HUE_SIXTH)) begin
      s8_next.sect = SEC_R_TO_Y;
    end else if (s7.hue < 9'(2 * HUE_SIXTH)) begin
      s8_next.sect = SEC_Y_TO_G;
    end else if (s7.hue < 9'(3 * HUE_SIXTH)) begin
      s8_next.sect = SEC_G_TO_C;
    end else if (s7.hue < 9'(4 * HUE_SIXTH)) begin
      s8_next.sect = SEC_C_TO_B;
    end else if (s7.hue < 9'(5 * HUE_SIXTH)) begin
      s8_next.sect = SEC_B_TO_M;
    end else begin
      s8_next.sect = SEC_M_TO_R;
    end
    s8_next.prod = {6'b0, s7.side.chroma} * {8'b0, t};
    s8_next.side = s7.side;
  end

  // stage 9: divide by 60 through the reciprocal
  always_comb begin
    logic [28:0] scaled;
    scaled       = {15'b0, s8.prod} * {14'b0, RECIP_SIXTH};
    s9_next.cc   = scaled[RECIP_SHIFT +: 8];
    s9_next.sect = s8.sect;
    s9_next.side = s8.side;
  end

  // stage 10: rebuild channels from the sector, add the minimum back
  always_comb begin
    logic [7:0] ro, go, bo, c;
    c = s9.side.chroma;
    case (s9.sect)
      SEC_R_TO_Y: begin ro = c;     go = s9.cc; bo = 8'd0;  end
      SEC_Y_TO_G: begin ro = s9.cc; go = c;     bo = 8'd0;  end
      SEC_G_TO_C: begin ro = 8'd0;  go = c;     bo = s9.cc; end
      SEC_C_TO_B: begin ro = 8'd0;  go = s9.cc; bo = c;     end
      SEC_B_TO_M: begin ro = s9.cc; go = 8'd0;  bo = c;     end
      default:    begin ro = c;     go = 8'd0;  bo = s9.cc; end
    endcase
    if (s9.side.bypass) begin
      s10_next.red_out   = s9.side.px.red_in;
      s10_next.green_out = s9.side.px.green_in;
      s10_next.blue_out  = s9.side.px.blue_in;
    end else begin
      s10_next.red_out   = ro + s9.side.lo;
      s10_next.green_out = go + s9.side.lo;
      s10_next.blue_out  = bo + s9.side.lo;
    end
    s10_next.alpha_out = s9.side.px.alpha_in;
  end

  // ready chain: a stage moves when empty or when its word moves on
  assign r10 = !v10 || out_ready;
  assign r9  = !v9 || r10;
  assign r8  = !v8 || r9;
  assign r7  = !v7 || r8;
  assign r6  = !v6 || r7;
  assign r5  = !v5 || r6;
  assign r1  = !v1 || div_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (r1)  v1  <= in_valid;
      if (r5)  v5  <= div_out_valid;
      if (r6)  v6  <= v5;
      if (r7)  v7  <= v6;
      if (r8)  v8  <= v7;
      if (r9)  v9  <= v8;
      if (r10) v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (r1)  s1       <= s1_next;
    if (r5)  s5       <= s5_next;
    if (r6)  s6       <= s6_next;
    if (r7)  s7       <= s7_next;
    if (r8)  s8       <= s8_next;
    if (r9)  s9       <= s9_next;
    if (r10) out_data <= s10_next;
  end

  assign in_ready  = r1;
  assign out_valid = v10;

  // an empty output stage means every stage can take a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with the output stage empty");

  // divider quotient is a hue below 360 for any colored pixel
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    div_out_valid && !div_out.side.bypass |-> div_out.quo < 9'(HUE_FULL))
    else $error("hue quotient out of range");

  // mod 360 reduction finished
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    v7 |-> s7.hue < 9'(HUE_FULL))
    else $error("rotated hue not reduced below 360");

  // a blocked stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v5 && !r6 |=> v5 && $stable(s5.mag))
    else $error("stage 5 word lost under stall");

endmodule
